@@ hw/rtl/att_pkg.sv @@
package att_pkg;

  // Table geometry
  localparam int SLOTS     = 128;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIVE_BITS = $clog2(SLOTS + 1);
  localparam int ADDR_BITS = 32;
  // Stored address bits: the input field is 32 bits wide
  localparam int KEY_BITS  = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  // Configuration port
  localparam int CFG_ADDR_BITS      = 3;
  localparam int CFG_DATA_BITS      = 32;
  localparam logic REG_MONITOR_ENABLE = 1'b0;

  // Item commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [2:0] RES_RECORDED   = 3'd0;
  localparam logic [2:0] RES_TABLE_FULL = 3'd1;
  localparam logic [2:0] RES_FAILED     = 3'd2;
  localparam logic [2:0] RES_FREED      = 3'd3;
  localparam logic [2:0] RES_UNTRACKED  = 3'd4;
  localparam logic [2:0] RES_SKIPPED    = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic [31:0] size_bytes;
  } att_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot_index;
    logic [31:0] freed_size;
    logic [7:0]  live_count;
    logic [31:0] bytes_in_use;
    logic [31:0] peak_bytes;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
    logic [31:0] fail_count;
  } att_out_t;

  // One table entry in the slot memory
  typedef struct packed {
    logic [31:0]         size;
    logic [KEY_BITS-1:0] key;
  } att_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } att_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;
    logic hit;
    logic scan_end;
    logic out_free;
  } att_stat_t;

endpackage

@@ hw/rtl/att_ram.sv @@
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/att_ctrl.sv @@
module att_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  att_pkg::att_stat_t stat,
  output att_pkg::att_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  // Sequencing: take item, classify, scan slots unless the item is quick, commit into output register
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = stat.quick ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/att_dp.sv @@
module att_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               monitor_enable,
  input  att_pkg::att_in_t   in_item,
  input  att_pkg::att_cmd_t  cmd,
  output att_pkg::att_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output att_pkg::att_out_t  out_item
);

  localparam logic [att_pkg::SLOT_BITS-1:0] LAST_SLOT =
    att_pkg::SLOT_BITS'(att_pkg::SLOTS - 1);

  // Held item
  logic                         it_cmd;
  logic [att_pkg::KEY_BITS-1:0] it_key;
  logic [31:0]                  it_size;

  // Scan state
  logic [att_pkg::SLOT_BITS-1:0] rd_idx;
  logic                          rd_more;
  logic                          chk_valid;
  logic [att_pkg::SLOT_BITS-1:0] chk_idx;
  logic                          found;
  logic [att_pkg::SLOT_BITS-1:0] found_idx;
  logic [31:0]                   found_size;

  // Table state and totals
  logic [att_pkg::SLOTS-1:0]     slot_valid;
  logic [31:0]                   alloc_total;
  logic [31:0]                   free_total;
  logic [31:0]                   fail_total;
  logic [att_pkg::LIVE_BITS-1:0] live_total;
  logic [31:0]                   in_use;
  logic [31:0]                   peak;

  logic [31:0]                   alloc_total_next;
  logic [31:0]                   free_total_next;
  logic [31:0]                   fail_total_next;
  logic [att_pkg::LIVE_BITS-1:0] live_total_next;
  logic [31:0]                   in_use_next;
  logic [31:0]                   peak_next;
  logic [2:0]                    res_status;

  att_pkg::att_entry_t rd_entry;
  att_pkg::att_entry_t wr_entry;
  logic                slot_we;
  logic                is_alloc;
  logic                hit;

  assign is_alloc = (it_cmd == att_pkg::CMD_ALLOC);

  // Slot memory: address and size per slot
  assign wr_entry.size = it_size;
  assign wr_entry.key  = it_key;
  assign slot_we       = cmd.commit && (res_status == att_pkg::RES_RECORDED);

  att_ram #(
    .WIDTH($bits(att_pkg::att_entry_t)),
    .DEPTH(att_pkg::SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (slot_we),
    .waddr(found_idx),
    .wdata(wr_entry),
    .raddr(rd_idx),
    .rdata(rd_entry)
  );

  // Check stage: free slot on allocate, valid matching slot on free
  always_comb begin
    if (is_alloc) begin
      hit = chk_valid && !slot_valid[chk_idx];
    end else begin
      hit = chk_valid && slot_valid[chk_idx] && (rd_entry.key == it_key);
    end
  end

  assign stat.quick    = !monitor_enable || (is_alloc && (it_key == '0));
  assign stat.hit      = hit;
  assign stat.scan_end = chk_valid && (chk_idx == LAST_SLOT);
  assign stat.out_free = !out_valid || !out_stall;

  // Item capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_cmd  <= in_item.cmd;
      it_key  <= in_item.addr[att_pkg::KEY_BITS-1:0];
      it_size <= in_item.size_bytes;
    end
    if (cmd.scan && hit) begin
      found_idx  <= chk_idx;
      found_size <= rd_entry.size;
    end
  end

  // Read issue and check pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      rd_more   <= 1'b0;
      chk_valid <= 1'b0;
      chk_idx   <= '0;
      found     <= 1'b0;
    end else if (cmd.load) begin
      rd_idx    <= '0;
      rd_more   <= 1'b1;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= rd_more;
      chk_idx   <= rd_idx;
      if (rd_more) begin
        if (rd_idx == LAST_SLOT) begin
          rd_more <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  // Outcome of the item
  always_comb begin
    if (!monitor_enable) begin
      res_status = att_pkg::RES_SKIPPED;
    end else if (is_alloc) begin
      if (it_key == '0) begin
        res_status = att_pkg::RES_FAILED;
      end else if (found) begin
        res_status = att_pkg::RES_RECORDED;
      end else begin
        res_status = att_pkg::RES_TABLE_FULL;
      end
    end else if (found) begin
      res_status = att_pkg::RES_FREED;
    end else begin
      res_status = att_pkg::RES_UNTRACKED;
    end
  end

  // Totals after the item
  always_comb begin
    alloc_total_next = alloc_total;
    free_total_next  = free_total;
    fail_total_next  = fail_total;
    live_total_next  = live_total;
    in_use_next      = in_use;
    peak_next        = peak;
    case (res_status)
      att_pkg::RES_RECORDED: begin
        alloc_total_next = alloc_total + 32'd1;
        live_total_next  = live_total + att_pkg::LIVE_BITS'(1);
        in_use_next      = in_use + it_size;
        if (in_use_next > peak) begin
          peak_next = in_use_next;
        end
      end
      att_pkg::RES_FREED: begin
        free_total_next = free_total + 32'd1;
        live_total_next = live_total - att_pkg::LIVE_BITS'(1);
        in_use_next     = in_use - found_size;
      end
      att_pkg::RES_FAILED: begin
        fail_total_next = fail_total + 32'd1;
      end
      default: begin
      end
    endcase
  end

  // Committed state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      alloc_total <= '0;
      free_total  <= '0;
      fail_total  <= '0;
      live_total  <= '0;
      in_use      <= '0;
      peak        <= '0;
    end else if (cmd.commit) begin
      alloc_total <= alloc_total_next;
      free_total  <= free_total_next;
      fail_total  <= fail_total_next;
      live_total  <= live_total_next;
      in_use      <= in_use_next;
      peak        <= peak_next;
      if (res_status == att_pkg::RES_RECORDED) begin
        slot_valid[found_idx] <= 1'b1;
      end else if (res_status == att_pkg::RES_FREED) begin
        slot_valid[found_idx] <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.status       <= res_status;
      // slot only where a slot was written or cleared, size only where one was cleared
      out_item.slot_index   <= (res_status == att_pkg::RES_RECORDED ||
                                res_status == att_pkg::RES_FREED) ? 7'(found_idx) : '0;
      out_item.freed_size   <= (res_status == att_pkg::RES_FREED) ? found_size : '0;
      out_item.live_count   <= 8'(live_total_next);
      out_item.bytes_in_use <= in_use_next;
      out_item.peak_bytes   <= peak_next;
      out_item.alloc_count  <= alloc_total_next;
      out_item.free_count   <= free_total_next;
      out_item.fail_count   <= fail_total_next;
    end
  end

endmodule

@@ hw/rtl/allocation_tracking_table.sv @@
// Skipped items and failed allocations go from accept straight to the result;
//   others scan the slots to a match or the last slot, then commit the result.
// Throughput: one item at a time, accepted once the last result is committed; the scan
//   checks one slot per cycle through the read port; a stalled output holds the commit.
// Reset: all slots free, all totals and the peak zero, monitoring enabled.
//   No clearing pass: slot memory contents are only read behind a valid bit.
module allocation_tracking_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  att_pkg::att_in_t                   in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output att_pkg::att_out_t                  out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [att_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [att_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [att_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  logic               monitor_enable;
  logic               reg_sel;
  att_pkg::att_cmd_t  cmd;
  att_pkg::att_stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == att_pkg::REG_MONITOR_ENABLE);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      monitor_enable <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? att_pkg::CFG_DATA_BITS'(monitor_enable) : '0;

  att_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  att_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .monitor_enable(monitor_enable),
    .in_item       (in_item),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item)
  );

endmodule

@@ test/allocation_tracking_table_tb.sv @@
`timescale 1ns / 100ps

module allocation_tracking_table_tb;

  // Directed table row kinds
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG  = 1'b1;
  localparam int   N_STEPS  = 20;
  localparam int   RANDOM_PER_PHASE = 167;

  // A config row carries the enable value in addr[0]
  typedef struct packed {
    logic             kind;
    logic             typed;
    logic [2:0]       status;
    att_pkg::att_in_t item;
  } step_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  att_pkg::att_in_t in_item;
  logic out_valid;
  logic out_stall = 1'b0;
  att_pkg::att_out_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [att_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [att_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [att_pkg::CFG_DATA_BITS-1:0] prdata;
  logic pready;

  // Shadow copy of the table and its totals
  logic        slot_used [att_pkg::SLOTS];
  logic [31:0] slot_key [att_pkg::SLOTS];
  logic [31:0] slot_len [att_pkg::SLOTS];
  logic [31:0] bytes_held = '0;
  logic [31:0] peak_held = '0;
  logic [31:0] allocs_done = '0;
  logic [31:0] frees_done = '0;
  logic [31:0] fails_done = '0;
  int          live_slots = 0;
  logic        monitor_on = 1'b1;

  att_pkg::att_out_t expected_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_tally [8];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Hand-checked opening sequence: extremes, every status but table full, duplicate addresses
  step_row_t directed_steps [N_STEPS] = '{
    {ROW_ITEM, 1'b1, att_pkg::RES_UNTRACKED, att_pkg::CMD_FREE, 32'h0000_0000, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_FAILED, att_pkg::CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF},
    {ROW_ITEM, 1'b1, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {ROW_ITEM, 1'b1, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'h0000_0001, 32'h0000_0000},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'h8000_0000, 32'h0000_0001},
    {ROW_ITEM, 1'b1, att_pkg::RES_UNTRACKED, att_pkg::CMD_FREE, 32'h0000_1234, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_FREED, att_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'h0000_0000},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'hAAAA_5555, 32'h5555_AAAA},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'h8000_0000, 32'h0000_0007},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_FREE, 32'h8000_0000, 32'hFFFF_FFFF},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_FREE, 32'h8000_0000, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_UNTRACKED, att_pkg::CMD_FREE, 32'h8000_0000, 32'h0000_0000},
    {ROW_CFG,  1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_SKIPPED, att_pkg::CMD_ALLOC, 32'h0000_0005, 32'h0000_0005},
    {ROW_ITEM, 1'b1, att_pkg::RES_SKIPPED, att_pkg::CMD_FREE, 32'hAAAA_5555, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_SKIPPED, att_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000},
    {ROW_CFG,  1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_ALLOC, 32'h0000_0001, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_FREED, att_pkg::CMD_FREE, 32'h0000_0001, 32'h0000_0000},
    {ROW_ITEM, 1'b0, att_pkg::RES_RECORDED, att_pkg::CMD_FREE, 32'hAAAA_5555, 32'h0000_0000},
    {ROW_ITEM, 1'b1, att_pkg::RES_FAILED, att_pkg::CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF}
  };

  allocation_tracking_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one item to the shadow table and returns the result it should give
  function automatic att_pkg::att_out_t track_item(input att_pkg::att_in_t it);
    att_pkg::att_out_t r;
    int i;
    r = '0;
    r.status = att_pkg::RES_SKIPPED;
    if (monitor_on) begin
      if (it.cmd == att_pkg::CMD_ALLOC) begin
        if (it.addr == '0) begin
          fails_done++;
          r.status = att_pkg::RES_FAILED;
        end else begin
          r.status = att_pkg::RES_TABLE_FULL;
          for (i = 0; i < att_pkg::SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_key[i] = it.addr;
              slot_len[i] = it.size_bytes;
              allocs_done++;
              live_slots++;
              bytes_held += it.size_bytes;
              if (bytes_held > peak_held) peak_held = bytes_held;
              r.status = att_pkg::RES_RECORDED;
              r.slot_index = 7'(i);
              break;
            end
          end
        end
      end else begin
        r.status = att_pkg::RES_UNTRACKED;
        for (i = 0; i < att_pkg::SLOTS; i++) begin
          if (slot_used[i] && slot_key[i] == it.addr) begin
            slot_used[i] = 1'b0;
            frees_done++;
            live_slots--;
            bytes_held -= slot_len[i];
            r.freed_size = slot_len[i];
            r.status = att_pkg::RES_FREED;
            r.slot_index = 7'(i);
            break;
          end
        end
      end
    end
    r.live_count = 8'(live_slots);
    r.bytes_in_use = bytes_held;
    r.peak_bytes = peak_held;
    r.alloc_count = allocs_done;
    r.free_count = frees_done;
    r.fail_count = fails_done;
    return r;
  endfunction

  // Address of some live slot, starting the search at a random place
  function automatic logic [31:0] any_live_key();
    int j;
    int k;
    j = $urandom_range(att_pkg::SLOTS - 1);
    for (k = 0; k < att_pkg::SLOTS; k++) begin
      if (slot_used[(j + k) % att_pkg::SLOTS]) return slot_key[(j + k) % att_pkg::SLOTS];
    end
    return $urandom;
  endfunction

  // Mostly well-formed traffic: allocations, frees of live blocks, some noise
  function automatic att_pkg::att_in_t random_item(input int alloc_w, input int free_w);
    att_pkg::att_in_t it;
    int roll;
    int pick;
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    it.size_bytes = $urandom_range(1) ? $urandom : $urandom_range(4096);
    if (roll < alloc_w) begin
      it.cmd = att_pkg::CMD_ALLOC;
      if (pick == 0) it.addr = '0;
      else if (pick < 3 && live_slots > 0) it.addr = any_live_key();
      else if (pick < 5) it.addr = $urandom_range(255, 1);
      else it.addr = $urandom;
    end else if (roll < alloc_w + free_w && live_slots > 0) begin
      it.cmd = att_pkg::CMD_FREE;
      it.addr = any_live_key();
    end else begin
      it.cmd = att_pkg::CMD_FREE;
      if (pick == 0) it.addr = '0;
      else if (pick < 4) it.addr = $urandom_range(255, 1);
      else it.addr = $urandom;
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at %0t ns: expected %h, got %h", name, $time, want, got);
    end
  endtask

  // Present one item, wait for acceptance, then queue its expected result
  task automatic send_item(input att_pkg::att_in_t it, input logic typed,
                           input logic [2:0] status);
    att_pkg::att_out_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = track_item(it);
    if (typed) want.status = status;
    expected_results.push_back(want);
    items_sent++;
  endtask

  // Register write once the block has drained, then read back
  task automatic write_monitor_enable(input logic on);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {att_pkg::REG_MONITOR_ENABLE, 2'b00};
    pwdata <= att_pkg::CFG_DATA_BITS'(on);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    monitor_on = on;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("monitor_enable", 32'(prdata[0]), 32'(on));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result with the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    att_pkg::att_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      status_tally[out_item.status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result at %0t ns with no item outstanding: status %0d",
                   $time, out_item.status);
      end else begin
        want = expected_results.pop_front();
        check_field("status",       32'(out_item.status),     32'(want.status));
        check_field("slot_index",   32'(out_item.slot_index), 32'(want.slot_index));
        check_field("freed_size",   out_item.freed_size,      want.freed_size);
        check_field("live_count",   32'(out_item.live_count), 32'(want.live_count));
        check_field("bytes_in_use", out_item.bytes_in_use,    want.bytes_in_use);
        check_field("peak_bytes",   out_item.peak_bytes,      want.peak_bytes);
        check_field("alloc_count",  out_item.alloc_count,     want.alloc_count);
        check_field("free_count",   out_item.free_count,      want.free_count);
        check_field("fail_count",   out_item.fail_count,      want.fail_count);
      end
    end
  end

  initial begin : stimulus
    att_pkg::att_in_t it;
    int n;
    int ph;
    int alloc_w;
    int free_w;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (n = 0; n < att_pkg::SLOTS; n++) slot_used[n] = 1'b0;
    for (n = 0; n < 8; n++) status_tally[n] = 0;
    send_idle_pct = 26;
    recv_stall_pct = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    for (n = 0; n < N_STEPS; n++) begin
      if (directed_steps[n].kind == ROW_CFG)
        write_monitor_enable(directed_steps[n].item.addr[0]);
      else
        send_item(directed_steps[n].item, directed_steps[n].typed, directed_steps[n].status);
    end

    // Random part, three idling profiles; the last one has no idling and mostly allocates
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 26;
          recv_stall_pct = 50;
          alloc_w = 50;
          free_w = 30;
        end
        1: begin
          send_idle_pct = 50;
          recv_stall_pct = 26;
          alloc_w = 40;
          free_w = 40;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          alloc_w = 75;
          free_w = 15;
        end
      endcase
      write_monitor_enable(1'b1);
      for (n = 0; n < RANDOM_PER_PHASE; n++)
        send_item(random_item(alloc_w, free_w), 1'b0, att_pkg::RES_RECORDED);
      // short stretch with monitoring off
      if (ph == 0) begin
        write_monitor_enable(1'b0);
        for (n = 0; n < 8; n++)
          send_item(random_item(alloc_w, free_w), 1'b0, att_pkg::RES_RECORDED);
      end
    end

    // Top up to a full table, overflow it, then reuse a middle slot
    it.cmd = att_pkg::CMD_ALLOC;
    while (live_slots < att_pkg::SLOTS) begin
      it.addr = $urandom_range(32'hFFFF_FFFF, 1);
      it.size_bytes = $urandom_range(4096);
      send_item(it, 1'b0, att_pkg::RES_RECORDED);
    end
    it.addr = $urandom_range(32'hFFFF_FFFF, 1);
    send_item(it, 1'b1, att_pkg::RES_TABLE_FULL);
    it.cmd = att_pkg::CMD_FREE;
    it.addr = slot_key[att_pkg::SLOTS / 2];
    send_item(it, 1'b0, att_pkg::RES_RECORDED);
    it.cmd = att_pkg::CMD_ALLOC;
    it.addr = $urandom_range(32'hFFFF_FFFF, 1);
    send_item(it, 1'b0, att_pkg::RES_RECORDED);

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (att_pkg::SLOTS + 8) @(posedge clk);
    $display("run covered %0d items and %0d results over three idling profiles",
             items_sent, results_seen);
    $display("statuses: %0d recorded, %0d full, %0d failed, %0d freed, %0d untracked",
             status_tally[att_pkg::RES_RECORDED], status_tally[att_pkg::RES_TABLE_FULL],
             status_tally[att_pkg::RES_FAILED], status_tally[att_pkg::RES_FREED],
             status_tally[att_pkg::RES_UNTRACKED]);
    $display("          %0d skipped", status_tally[att_pkg::RES_SKIPPED]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/att_pkg.sv
hw/rtl/att_ram.sv
hw/rtl/att_ctrl.sv
hw/rtl/att_dp.sv
hw/rtl/allocation_tracking_table.sv
test/allocation_tracking_table_tb.sv
